[rtl/core/multichannel_moving_average_top_assert.svh]
// Assertion macros for the moving-average block.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef MULTICHANNEL_MOVING_AVERAGE_TOP_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition holds at every clock edge outside reset.
`define MMA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MMA_ASSERT_ALWAYS(label, cond, msg)
`define MMA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/core/mma_pkg.sv]
// Shared constants and types for the moving-average block.
// No dependencies; used by mma_div and the top level in rtl/core.
package mma_pkg;

  localparam int MAX_SECTORS  = 8;
  localparam int MAX_WINDOW   = 64;   // power of two: ring pointers wrap by truncation
  localparam int SAMPLE_BITS  = 16;

  localparam int SECTOR_BITS  = 3;
  localparam int PTR_BITS     = $clog2(MAX_WINDOW);
  localparam int COUNT_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
  localparam int ADDR_BITS    = SECTOR_BITS + PTR_BITS;
  localparam int STORE_DEPTH  = MAX_SECTORS * MAX_WINDOW;
  localparam int STEP_BITS    = $clog2(SUM_BITS + 1);

  localparam int WINLEN_BITS    = 7;
  localparam int ACTSEC_BITS    = 4;
  localparam int CFG_DATA_BITS  = 7;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_SECTORS = CFG_INDEX_BITS'(1);

  localparam logic [WINLEN_BITS-1:0] WINDOW_LENGTH_RESET  = WINLEN_BITS'(16);
  localparam logic [ACTSEC_BITS-1:0] ACTIVE_SECTORS_RESET = ACTSEC_BITS'(8);

  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/mma_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/mma_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on mma_pkg for widths and the request/response structs.
module mma_div (
  input  logic              clk,
  input  logic              rst,
  input  mma_pkg::div_req_t req,
  output mma_pkg::div_rsp_t rsp
);

  logic [mma_pkg::COUNT_BITS-1:0] rem;
  logic [mma_pkg::SUM_BITS-1:0]   quo;
  logic [mma_pkg::COUNT_BITS-1:0] div;
  logic [mma_pkg::STEP_BITS-1:0]  step;
  logic                           busy;
  logic                           done;

  logic [mma_pkg::COUNT_BITS:0]   shifted;
  logic                           ge;
  logic [mma_pkg::COUNT_BITS:0]   diff;
  logic [mma_pkg::COUNT_BITS-1:0] rem_next;
  logic [mma_pkg::SUM_BITS-1:0]   quo_next;

  // The remainder stays below the divisor, so the shifted value fits one extra bit.
  always_comb begin
    shifted  = {rem, quo[mma_pkg::SUM_BITS-1]};
    ge       = shifted >= {1'b0, div};
    diff     = shifted - {1'b0, div};
    rem_next = ge ? diff[mma_pkg::COUNT_BITS-1:0] : shifted[mma_pkg::COUNT_BITS-1:0];
    quo_next = {quo[mma_pkg::SUM_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        div  <= req.divisor;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= quo_next;
        step <= step + mma_pkg::STEP_BITS'(1);
        if (step == mma_pkg::STEP_BITS'(mma_pkg::SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[rtl/core/multichannel_moving_average_top.sv]
// Top level of the per-sector boxcar moving average.
// Depends on mma_pkg, mma_ram, mma_div and multichannel_moving_average_top_assert.svh.
//
//   channel  signals                                       direction
//   in       in_valid, in_stall, sector_index, energy_sample  sample beats in
//   out      out_valid, out_stall, report_sector, average_value,
//            window_empty, bad_sector, last_report            one beat per active sector
//   cfg      cfg_write, cfg_index, cfg_data                   register writes, no read-back
//
// One input beat passes through the window update (idle, check, then drop only for a
// full window, then append; a rejected beat skips all but idle) and then, for every
// active sector, through the request, a 22-step pass of the shared divider and the
// output beat; an empty sector skips the divider. Reset is synchronous and clears the
// per-sector counts, pointers and sums; the store is not cleared, as every entry is
// written before it is read. in_stall is high whenever the sequencer is not idle, and
// out_stall holds the pending output beat, stretching the item.
module multichannel_moving_average_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mma_pkg::SECTOR_BITS-1:0]     sector_index,
  input  logic [mma_pkg::SAMPLE_BITS-1:0]     energy_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mma_pkg::SECTOR_BITS-1:0]     report_sector,
  output logic [mma_pkg::SAMPLE_BITS-1:0]     average_value,
  output logic                                window_empty,
  output logic                                bad_sector,
  output logic                                last_report,
  input  logic                                cfg_write,
  input  logic [mma_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mma_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DROP,
    ST_APPEND,
    ST_RPT_START,
    ST_RPT_DIV,
    ST_RPT_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [mma_pkg::WINLEN_BITS-1:0] window_length;
  logic [mma_pkg::ACTSEC_BITS-1:0] active_sectors;

  // Per-sector state, all read through the one sector select register.
  logic [mma_pkg::PTR_BITS-1:0]   oldest_pointer [mma_pkg::MAX_SECTORS];
  logic [mma_pkg::COUNT_BITS-1:0] sample_count   [mma_pkg::MAX_SECTORS];
  logic [mma_pkg::SUM_BITS-1:0]   running_sum    [mma_pkg::MAX_SECTORS];

  logic [mma_pkg::SECTOR_BITS-1:0] sel;
  logic [mma_pkg::SAMPLE_BITS-1:0] sample;
  logic                            bad;

  logic [mma_pkg::COUNT_BITS-1:0]  win_eff;
  logic [mma_pkg::ACTSEC_BITS-1:0] nsec;
  logic [mma_pkg::ACTSEC_BITS-1:0] nsec_last;
  logic                            in_bad;
  logic                            sel_is_last;

  logic [mma_pkg::PTR_BITS-1:0]   oldest_sel;
  logic [mma_pkg::COUNT_BITS-1:0] count_sel;
  logic [mma_pkg::SUM_BITS-1:0]   sum_sel;
  logic [mma_pkg::COUNT_BITS-1:0] wr_pos_full;

  logic                            ram_we;
  logic [mma_pkg::ADDR_BITS-1:0]   ram_waddr;
  logic                            ram_re;
  logic [mma_pkg::ADDR_BITS-1:0]   ram_raddr;
  logic [mma_pkg::SAMPLE_BITS-1:0] ram_rdata;

  mma_pkg::div_req_t div_req;
  mma_pkg::div_rsp_t div_rsp;

  // Out-of-range register values are clamped into the meaningful range.
  always_comb begin
    if (window_length == '0) begin
      win_eff = mma_pkg::COUNT_BITS'(1);
    end else if (window_length > mma_pkg::WINLEN_BITS'(mma_pkg::MAX_WINDOW)) begin
      win_eff = mma_pkg::COUNT_BITS'(mma_pkg::MAX_WINDOW);
    end else begin
      win_eff = mma_pkg::COUNT_BITS'(window_length);
    end
    if (active_sectors == '0) begin
      nsec = mma_pkg::ACTSEC_BITS'(1);
    end else if (active_sectors > mma_pkg::ACTSEC_BITS'(mma_pkg::MAX_SECTORS)) begin
      nsec = mma_pkg::ACTSEC_BITS'(mma_pkg::MAX_SECTORS);
    end else begin
      nsec = active_sectors;
    end
  end

  assign nsec_last   = nsec - mma_pkg::ACTSEC_BITS'(1);
  assign in_bad      = mma_pkg::ACTSEC_BITS'(sector_index) >= nsec;
  assign sel_is_last = mma_pkg::ACTSEC_BITS'(sel) == nsec_last;

  assign oldest_sel  = oldest_pointer[sel];
  assign count_sel   = sample_count[sel];
  assign sum_sel     = running_sum[sel];

  // The new sample lands count slots past the oldest one; the ring wraps on truncation.
  assign wr_pos_full = mma_pkg::COUNT_BITS'(oldest_sel) + count_sel;

  assign ram_re    = (state == ST_CHECK);
  assign ram_raddr = {sel, oldest_sel};
  assign ram_we    = (state == ST_APPEND);
  assign ram_waddr = {sel, wr_pos_full[mma_pkg::PTR_BITS-1:0]};

  assign div_req.start    = (state == ST_RPT_START) && (count_sel != '0);
  assign div_req.dividend = sum_sel;
  assign div_req.divisor  = count_sel;

  assign in_stall = (state != ST_IDLE);

  mma_ram #(
    .WIDTH(mma_pkg::SAMPLE_BITS),
    .DEPTH(mma_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(sample),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mma_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= mma_pkg::WINDOW_LENGTH_RESET;
      active_sectors <= mma_pkg::ACTIVE_SECTORS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mma_pkg::REG_WINDOW_LENGTH:  window_length  <= cfg_data[mma_pkg::WINLEN_BITS-1:0];
        mma_pkg::REG_ACTIVE_SECTORS: active_sectors <= cfg_data[mma_pkg::ACTSEC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sel       <= '0;
      for (int s = 0; s < mma_pkg::MAX_SECTORS; s++) begin
        oldest_pointer[s] <= '0;
        sample_count[s]   <= '0;
        running_sum[s]    <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sample <= energy_sample;
            bad    <= in_bad;
            if (in_bad) begin
              sel   <= '0;
              state <= ST_RPT_START;
            end else begin
              sel   <= sector_index;
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          // A full window first drops its oldest sample, read from the store here.
          if (count_sel >= win_eff) begin
            state <= ST_DROP;
          end else begin
            state <= ST_APPEND;
          end
        end
        ST_DROP: begin
          running_sum[sel]    <= sum_sel - mma_pkg::SUM_BITS'(ram_rdata);
          oldest_pointer[sel] <= oldest_sel + mma_pkg::PTR_BITS'(1);
          sample_count[sel]   <= count_sel - mma_pkg::COUNT_BITS'(1);
          state               <= ST_APPEND;
        end
        ST_APPEND: begin
          running_sum[sel]  <= sum_sel + mma_pkg::SUM_BITS'(sample);
          sample_count[sel] <= count_sel + mma_pkg::COUNT_BITS'(1);
          sel               <= '0;
          state             <= ST_RPT_START;
        end
        ST_RPT_START: begin
          report_sector <= sel;
          bad_sector    <= bad;
          last_report   <= sel_is_last;
          if (count_sel == '0) begin
            average_value <= '0;
            window_empty  <= 1'b1;
            out_valid     <= 1'b1;
            state         <= ST_RPT_OUT;
          end else begin
            state <= ST_RPT_DIV;
          end
        end
        ST_RPT_DIV: begin
          if (div_rsp.done) begin
            // The mean never exceeds the largest sample, so truncation loses nothing.
            average_value <= div_rsp.quotient[mma_pkg::SAMPLE_BITS-1:0];
            window_empty  <= 1'b0;
            out_valid     <= 1'b1;
            state         <= ST_RPT_OUT;
          end
        end
        ST_RPT_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (sel_is_last) begin
              state <= ST_IDLE;
            end else begin
              sel   <= sel + mma_pkg::SECTOR_BITS'(1);
              state <= ST_RPT_START;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "multichannel_moving_average_top_assert.svh"

  // A result beat is only ever offered while the input side is held off.
  `MMA_ASSERT_ALWAYS(a_out_excludes_in, !out_valid || in_stall, "output beat while input open")
  // The final beat of an item returns the sequencer to idle.
  `MMA_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && last_report, !in_stall, "no idle")
  // The last flag marks exactly the highest active sector.
  `MMA_ASSERT_ALWAYS(a_last_sector, !out_valid || (last_report == sel_is_last), "bad last flag")
  // The selected sector never holds more samples than its share of the store has room for.
  `MMA_ASSERT_ALWAYS(a_count_bound, count_sel <= mma_pkg::COUNT_BITS'(mma_pkg::MAX_WINDOW), "count")

endmodule

[test/tb_multichannel_moving_average_top.sv]
// Testbench for multichannel_moving_average_top: drives sample beats, predicts every
// per-sector average beat, and checks them field by field in arrival order.
// Depends on mma_pkg and the RTL of multichannel_moving_average_top.
module tb_multichannel_moving_average_top;

  // Register indexes that decode to nothing; writes to them must leave both registers alone.
  localparam logic [mma_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = mma_pkg::CFG_INDEX_BITS'(2);
  localparam logic [mma_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = mma_pkg::CFG_INDEX_BITS'(3);

  // Cycles allowed after the last expected beat before the block counts as quiet.
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [mma_pkg::SECTOR_BITS-1:0] sector;
    logic [mma_pkg::SAMPLE_BITS-1:0] sample;
  } sample_beat_t;

  typedef struct {
    logic [mma_pkg::SECTOR_BITS-1:0] sector;
    logic [mma_pkg::SAMPLE_BITS-1:0] value;
    logic                            empty;
    logic                            rejected;
    logic                            last_flag;
  } avg_report_t;

  logic clk;
  logic rst = 1'b1;

  logic                               in_valid      = 1'b0;
  logic                               in_stall;
  logic [mma_pkg::SECTOR_BITS-1:0]    sector_index  = '0;
  logic [mma_pkg::SAMPLE_BITS-1:0]    energy_sample = '0;
  logic                               out_valid;
  logic                               out_stall     = 1'b0;
  logic [mma_pkg::SECTOR_BITS-1:0]    report_sector;
  logic [mma_pkg::SAMPLE_BITS-1:0]    average_value;
  logic                               window_empty;
  logic                               bad_sector;
  logic                               last_report;
  logic                               cfg_write     = 1'b0;
  logic [mma_pkg::CFG_INDEX_BITS-1:0] cfg_index     = '0;
  logic [mma_pkg::CFG_DATA_BITS-1:0]  cfg_data      = '0;

  multichannel_moving_average_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sector_index  (sector_index),
    .energy_sample (energy_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .report_sector (report_sector),
    .average_value (average_value),
    .window_empty  (window_empty),
    .bad_sector    (bad_sector),
    .last_report   (last_report),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock with a period of 4.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs. The limit is set above the slowest correct run,
  // in which every beat reports eight sectors and each output beat is held off by a full
  // stall burst.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Predictor state: our own copy of the two registers and of every sector's window.
  // ---------------------------------------------------------------------------------
  logic [mma_pkg::WINLEN_BITS-1:0] win_len_reg = mma_pkg::WINDOW_LENGTH_RESET;
  logic [mma_pkg::ACTSEC_BITS-1:0] act_sec_reg = mma_pkg::ACTIVE_SECTORS_RESET;

  logic [mma_pkg::SAMPLE_BITS-1:0] win_store  [mma_pkg::MAX_SECTORS][mma_pkg::MAX_WINDOW];
  logic [mma_pkg::PTR_BITS-1:0]    head_ptr   [mma_pkg::MAX_SECTORS];
  logic [mma_pkg::COUNT_BITS-1:0]  fill_count [mma_pkg::MAX_SECTORS];
  logic [mma_pkg::SUM_BITS-1:0]    win_sum    [mma_pkg::MAX_SECTORS];

  sample_beat_t sample_q[$];          // beats waiting for the input driver
  avg_report_t  pending_averages[$];  // averages the block still owes us

  int  mismatches  = 0;
  bit  beat_taken  = 1'b0;  // the input beat on the bus was accepted at the last edge
  int  in_gap      = 0;
  int  stall_left  = 0;
  int  in_gap_odds = 4;     // one in N beats is followed by an idle burst; 0 means none
  int  stall_odds  = 6;     // odds 1 in N of a new output stall burst while none runs; 0 means none

  initial begin
    for (int s = 0; s < mma_pkg::MAX_SECTORS; s++) begin
      head_ptr[s]   = '0;
      fill_count[s] = '0;
      win_sum[s]    = '0;
    end
  end

  // A zero register value counts as the smallest setting and anything past the top
  // of the range is clamped.
  function automatic int live_window();
    if (win_len_reg == 0) return 1;
    if (int'(win_len_reg) > mma_pkg::MAX_WINDOW) return mma_pkg::MAX_WINDOW;
    return int'(win_len_reg);
  endfunction

  function automatic int live_sectors();
    if (act_sec_reg == 0) return 1;
    if (int'(act_sec_reg) > mma_pkg::MAX_SECTORS) return mma_pkg::MAX_SECTORS;
    return int'(act_sec_reg);
  endfunction

  // Folds one accepted sample into its sector's window and queues the averages of all
  // active sectors that the block must then report. A sector outside the active range
  // changes nothing but still produces a full set of beats, each marked as rejected.
  task automatic push_window_averages(input logic [mma_pkg::SECTOR_BITS-1:0] sec,
                                      input logic [mma_pkg::SAMPLE_BITS-1:0] smp);
    int          nsec;
    int          slot;
    logic        rejected;
    avg_report_t r;
    nsec     = live_sectors();
    rejected = (int'(sec) >= nsec);
    if (!rejected) begin
      // A full window (or one that is over length after a shrink) gives up exactly
      // one oldest sample per beat.
      if (int'(fill_count[sec]) >= live_window()) begin
        win_sum[sec]    = win_sum[sec] - mma_pkg::SUM_BITS'(win_store[sec][head_ptr[sec]]);
        head_ptr[sec]   = head_ptr[sec] + 1'b1;
        fill_count[sec] = fill_count[sec] - 1'b1;
      end
      slot = (int'(head_ptr[sec]) + int'(fill_count[sec])) % mma_pkg::MAX_WINDOW;
      win_store[sec][slot] = smp;
      win_sum[sec]    = win_sum[sec] + mma_pkg::SUM_BITS'(smp);
      fill_count[sec] = fill_count[sec] + 1'b1;
    end
    for (int s = 0; s < nsec; s++) begin
      r.sector    = mma_pkg::SECTOR_BITS'(s);
      r.rejected  = rejected;
      r.last_flag = (s == nsec - 1);
      if (fill_count[s] == 0) begin
        r.value = '0;
        r.empty = 1'b1;
      end else begin
        r.value = mma_pkg::SAMPLE_BITS'(win_sum[s] / fill_count[s]);
        r.empty = 1'b0;
      end
      pending_averages = {pending_averages, r};
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------------
  // Monitor: at every rising edge, check an accepted output beat against the oldest
  // expectation first, then apply register writes and accepted input beats to the
  // predictor. Doing both in one block keeps the queue order independent of the
  // scheduler.
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    avg_report_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_averages.size() == 0) begin
          report_mismatch("unexpected result beat, sector", report_sector, 0);
        end else begin
          want = pending_averages[0];
          pending_averages.delete(0);
          if (report_sector !== want.sector)
            report_mismatch("report_sector", report_sector, want.sector);
          if (average_value !== want.value)
            report_mismatch("average_value", average_value, want.value);
          if (window_empty !== want.empty)
            report_mismatch("window_empty", window_empty, want.empty);
          if (bad_sector !== want.rejected)
            report_mismatch("bad_sector", bad_sector, want.rejected);
          if (last_report !== want.last_flag)
            report_mismatch("last_report", last_report, want.last_flag);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          mma_pkg::REG_WINDOW_LENGTH:  win_len_reg = cfg_data[mma_pkg::WINLEN_BITS-1:0];
          mma_pkg::REG_ACTIVE_SECTORS: act_sec_reg = cfg_data[mma_pkg::ACTSEC_BITS-1:0];
          default: ;
        endcase
      end
      beat_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        push_window_averages(sector_index, energy_sample);
    end
  end

  // ---------------------------------------------------------------------------------
  // Input driver: on the falling edge, hold a beat until it is taken, then either
  // idle for the rest of a gap burst or present the next queued beat.
  // ---------------------------------------------------------------------------------
  always @(negedge clk) begin : sample_driver
    sample_beat_t nxt;
    if (!rst && (!in_valid || beat_taken)) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        nxt = sample_q[0];
        sample_q.delete(0);
        sector_index  <= nxt.sector;
        energy_sample <= nxt.sample;
        in_valid      <= 1'b1;
        if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1)
          in_gap <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure comes in random bursts, independent of out_valid,
  // so it lands on every point of the block's divider and output sequence.
  always @(negedge clk) begin : stall_driver
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        stall_left <= $urandom_range(1, 16);
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------
  task automatic write_reg(input logic [mma_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [mma_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_sample(input int sec, input int val);
    sample_beat_t b;
    b.sector = mma_pkg::SECTOR_BITS'(sec);
    b.sample = mma_pkg::SAMPLE_BITS'(val);
    sample_q = {sample_q, b};
  endtask

  // Registers may only change while the block is quiet: every queued beat has been
  // taken and every expected average has come back.
  task automatic wait_quiet();
    while (sample_q.size() != 0 || in_valid || pending_averages.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed beats aimed at active sectors; about one in eight targets a
  // sector beyond the active range when there is one. Samples lean toward full scale
  // and small values so that sums reach their widest and truncation shows.
  task automatic random_phase(input int n, input int wl, input int act);
    int nsec;
    int sec;
    int val;
    write_reg(mma_pkg::REG_WINDOW_LENGTH, mma_pkg::CFG_DATA_BITS'(wl));
    write_reg(mma_pkg::REG_ACTIVE_SECTORS, mma_pkg::CFG_DATA_BITS'(act));
    nsec = live_sectors();
    for (int k = 0; k < n; k++) begin
      if (nsec < mma_pkg::MAX_SECTORS && $urandom_range(0, 7) == 0)
        sec = $urandom_range(nsec, mma_pkg::MAX_SECTORS - 1);
      else
        sec = $urandom_range(0, nsec - 1);
      case ($urandom_range(0, 3))
        0:       val = 16'hFFFF;
        1:       val = $urandom_range(0, 255);
        default: val = $urandom;
      endcase
      queue_sample(sec, val);
    end
    wait_quiet();
  endtask

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 2;
      default: return 8;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: all sectors start empty, then take full-scale, zero, small and mid-scale samples.
    queue_sample(0, 16'hFFFF);
    queue_sample(7, 16'h0000);
    queue_sample(7, 16'hFFFF);
    queue_sample(3, 16'h0001);
    queue_sample(0, 16'h8000);
    wait_quiet();

    // Writes to the unused indexes must be ignored; a zero window length acts as one
    // and an active count beyond the top clamps to all sectors.
    write_reg(REG_SPARE_A, 7'h7F);
    write_reg(REG_SPARE_B, 7'h55);
    write_reg(mma_pkg::REG_WINDOW_LENGTH, 7'd0);
    write_reg(mma_pkg::REG_ACTIVE_SECTORS, 7'd15);
    queue_sample(3, 16'h1234);
    queue_sample(3, 16'hFFFF);
    queue_sample(5, 16'h00FF);
    wait_quiet();

    // Three active sectors with the window clamped to its maximum; sector 3 sits just
    // past the active range and sector 7 far past it.
    write_reg(mma_pkg::REG_ACTIVE_SECTORS, 7'd3);
    write_reg(mma_pkg::REG_WINDOW_LENGTH, 7'd127);
    queue_sample(2, 16'hABCD);
    queue_sample(3, 16'h1111);
    queue_sample(7, 16'hFFFF);
    queue_sample(0, 16'h0001);
    wait_quiet();

    // Zero active sectors acts as one; only sector 0 is reported.
    write_reg(mma_pkg::REG_ACTIVE_SECTORS, 7'd0);
    write_reg(mma_pkg::REG_WINDOW_LENGTH, 7'd2);
    queue_sample(0, 16'hAAAA);
    queue_sample(0, 16'h5555);
    queue_sample(0, 16'hFFFF);
    queue_sample(1, 16'h0001);
    wait_quiet();

    // All sectors back in use: the ones idle since the last phase report the window
    // they kept. Sector 1 then fills a four-deep window.
    write_reg(mma_pkg::REG_ACTIVE_SECTORS, 7'd8);
    write_reg(mma_pkg::REG_WINDOW_LENGTH, 7'd4);
    queue_sample(1, 16'hF0F0);
    queue_sample(1, 16'h0F0F);
    queue_sample(1, 16'hFFFF);
    queue_sample(1, 16'h0001);
    queue_sample(1, 16'h8000);
    wait_quiet();

    // Shrink the window under a full sector: one oldest sample leaves per beat.
    write_reg(mma_pkg::REG_WINDOW_LENGTH, 7'd1);
    queue_sample(1, 16'h7FFF);
    queue_sample(1, 16'h0002);
    wait_quiet();

    // Random phases. The first fills a single 64-deep window, about a quarter of its
    // samples at full scale, so the running sum runs high.
    in_gap_odds = pick_odds();
    stall_odds  = pick_odds();
    random_phase(70, 64, 1);
    in_gap_odds = pick_odds();
    stall_odds  = pick_odds();
    random_phase(25, 1, 8);
    in_gap_odds = pick_odds();
    stall_odds  = pick_odds();
    random_phase(40, $urandom_range(0, 127), $urandom_range(0, 15));
    in_gap_odds = pick_odds();
    stall_odds  = pick_odds();
    random_phase(40, 5, 4);
    in_gap_odds = pick_odds();
    stall_odds  = pick_odds();
    random_phase(40, 64, 8);
    in_gap_odds = pick_odds();
    stall_odds  = pick_odds();
    random_phase(25, 3, 8);

    // Closing phase runs at full rate on both sides.
    in_gap_odds = 0;
    stall_odds  = 0;
    random_phase(20, $urandom_range(0, 127), $urandom_range(0, 15));

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
